// ----- rtl/core/tdcrd_pkg.sv -----
// Shared codes and types for the TDC readout word decoder.
package tdcrd_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned CH_W   = 5;
  localparam int unsigned FT_W   = 16;
  localparam int unsigned HIT_W  = CH_W + FT_W;
  localparam int unsigned TS_W   = 46;
  localparam int unsigned TSLO_W = 30;
  localparam int unsigned TSHI_W = 16;
  localparam int unsigned CFGI_W = 4;
  localparam int unsigned CFGD_W = 8;

  // timestamp modes
  localparam logic [1:0] MODE_COUNTER = 2'd0;
  localparam logic [1:0] MODE_TS      = 2'd1;
  localparam logic [1:0] MODE_OFF     = 2'd2;
  localparam logic [1:0] MODE_EXT     = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_HIT      = 2'd0;
  localparam logic [1:0] KIND_BAD_HDR  = 2'd1;
  localparam logic [1:0] KIND_BAD_DATA = 2'd2;
  localparam logic [1:0] KIND_OVERFLOW = 2'd3;

  // register indexes
  localparam logic [CFGI_W-1:0] CFG_TS_MODE = 4'd0;
  localparam logic [CFGI_W-1:0] CFG_MODULE  = 4'd1;

  // word signatures
  localparam logic [1:0]  TOP_DATA   = 2'b00;
  localparam logic [1:0]  TOP_HEADER = 2'b01;
  localparam logic [1:0]  TOP_FILL   = 2'b10;
  localparam logic [1:0]  TOP_EOE    = 2'b11;
  localparam logic [7:0]  HDR_ID     = 8'd64;
  localparam logic [9:0]  HIT_ID     = 10'd16;
  localparam logic [15:0] EXT_ID     = 16'd1152;

  typedef enum logic [2:0] {
    WC_IGNORE,
    WC_HEADER,
    WC_HIT,
    WC_EXT,
    WC_BAD_DATA,
    WC_EOE
  } word_class_t;

  typedef struct packed {
    word_class_t       wclass;
    logic              header_bad;
    logic [CH_W-1:0]   channel;
    logic [FT_W-1:0]   fine;
    logic [TSLO_W-1:0] ts_low;
  } word_info_t;

endpackage

// ----- rtl/core/tdcrd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module tdcrd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic                 re,
  input  logic [AW-1:0]        raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/tdcrd_classify.sv -----
// Classifies one readout word and extracts its fields.
module tdcrd_classify (
  input  logic [tdcrd_pkg::WORD_W-1:0] word,
  input  logic [1:0]                   mode,
  output tdcrd_pkg::word_info_t        info
);

  always_comb begin
    info.header_bad = (word[31:24] != tdcrd_pkg::HDR_ID);
    info.channel    = word[20:16];
    info.fine       = word[15:0];
    info.ts_low     = word[29:0];
    info.wclass     = tdcrd_pkg::WC_IGNORE;
    if (mode != tdcrd_pkg::MODE_OFF) begin
      unique case (word[31:30])
        tdcrd_pkg::TOP_HEADER: info.wclass = tdcrd_pkg::WC_HEADER;
        tdcrd_pkg::TOP_DATA: begin
          if (word[31:22] == tdcrd_pkg::HIT_ID) begin
            info.wclass = tdcrd_pkg::WC_HIT;
          end else if (mode == tdcrd_pkg::MODE_EXT && word[31:16] == tdcrd_pkg::EXT_ID) begin
            info.wclass = tdcrd_pkg::WC_EXT;
          end else if (word != '0) begin
            info.wclass = tdcrd_pkg::WC_BAD_DATA;
          end
        end
        tdcrd_pkg::TOP_EOE:  info.wclass = tdcrd_pkg::WC_EOE;
        tdcrd_pkg::TOP_FILL: info.wclass = tdcrd_pkg::WC_IGNORE;
        default:             info.wclass = tdcrd_pkg::WC_IGNORE;
      endcase
    end
  end

endmodule

// ----- rtl/core/tdc_readout_word_decoder_unit.sv -----
// Top level: TDC readout word decoder with hit buffer in RAM.
// Decodes TDC readout words into hit and error results. A word is taken into a
// one-beat holding register, so a new word may be offered while a result still
// waits at the output; the register frees only once its word is decoded, which
// needs a free output. In timestamp modes 1 and 3 the hits of an event sit in
// a MAX_HITS-deep RAM with registered read; a header or an end-of-event word
// with pending hits drains them all (a bad header is reported after its drain),
// the drain reading one RAM entry per cycle and emitting one result beat per
// cycle while the output is free. The RAM needs no clearing: only entries below
// the fill count are ever read. Configuration registers are to be written only
// while the decoder is idle.
module tdc_readout_word_decoder_unit #(
  parameter int unsigned MAX_HITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [tdcrd_pkg::CFGI_W-1:0] cfg_index,
  input  logic [tdcrd_pkg::CFGD_W-1:0] cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [tdcrd_pkg::WORD_W-1:0] data_word,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   kind,
  output logic [7:0]                   module_id,
  output logic [tdcrd_pkg::CH_W-1:0]   channel,
  output logic [tdcrd_pkg::FT_W-1:0]   fine_time,
  output logic [tdcrd_pkg::TS_W-1:0]   timestamp,
  output logic                         timestamp_valid,
  output logic                         last_of_run
);
  localparam int unsigned AW = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
  localparam int unsigned CW = $clog2(MAX_HITS + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_HITS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAIN,
    ST_BAD_HDR
  } state_t;

  state_t                          state;
  logic                            word_valid;
  logic [tdcrd_pkg::WORD_W-1:0]    word;
  logic [1:0]                      ts_mode;
  logic [7:0]                      module_number;
  logic [tdcrd_pkg::TS_W-1:0]      event_counter;
  logic [CW-1:0]                   pending_count;
  logic [tdcrd_pkg::TSHI_W-1:0]    ts_high_bits;
  logic                            ts_high_seen;
  logic [CW-1:0]                   emit_idx;
  logic [tdcrd_pkg::TS_W-1:0]      drain_ts;
  logic                            drain_tv;
  logic                            bad_after;

  tdcrd_pkg::word_info_t           info;
  logic                            out_free;
  logic                            held;
  logic                            start_drain;
  logic                            last_hit;
  logic                            ram_we;
  logic                            ram_re;
  logic [AW-1:0]                   ram_raddr;
  logic [tdcrd_pkg::HIT_W-1:0]     ram_rdata;
  logic [CW-1:0]                   emit_idx_next;

  tdcrd_classify u_classify (
    .word (word),
    .mode (ts_mode),
    .info (info)
  );

  tdcrd_ram #(
    .WIDTH (tdcrd_pkg::HIT_W),
    .DEPTH (MAX_HITS)
  ) u_hit_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pending_count[AW-1:0]),
    .wdata ({info.channel, info.fine}),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cfg_ready     = 1'b1;
  assign in_ready      = !word_valid;
  assign out_free      = !out_valid || out_ready;
  assign held          = (ts_mode == tdcrd_pkg::MODE_TS) || (ts_mode == tdcrd_pkg::MODE_EXT);
  assign last_hit      = (emit_idx == pending_count - CW'(1));
  assign emit_idx_next = emit_idx + CW'(1);

  // Writes happen only on an idle hit word and reads only as a drain starts or
  // runs, so the same entry is never written and read in one cycle.
  always_comb begin
    start_drain = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = '0;
    unique case (state)
      ST_IDLE: begin
        if (word_valid && out_free) begin
          case (info.wclass) inside
            tdcrd_pkg::WC_HEADER,
            tdcrd_pkg::WC_EOE: start_drain = held && (pending_count != '0);
            tdcrd_pkg::WC_HIT: ram_we = held && (pending_count < CNT_MAX);
            default: ;
          endcase
          ram_re = start_drain;
        end
      end
      ST_DRAIN: begin
        if (out_free && !last_hit) begin
          ram_re    = 1'b1;
          ram_raddr = emit_idx_next[AW-1:0];
        end
      end
      ST_BAD_HDR: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      word_valid    <= 1'b0;
      out_valid     <= 1'b0;
      ts_mode       <= tdcrd_pkg::MODE_COUNTER;
      module_number <= '0;
      event_counter <= '0;
      pending_count <= '0;
      ts_high_bits  <= '0;
      ts_high_seen  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          tdcrd_pkg::CFG_TS_MODE: ts_mode       <= cfg_data[1:0];
          tdcrd_pkg::CFG_MODULE:  module_number <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        word       <= data_word;
        word_valid <= 1'b1;
      end
      if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (word_valid && out_free) begin
            word_valid      <= 1'b0;
            module_id       <= module_number;
            channel         <= '0;
            fine_time       <= '0;
            timestamp       <= '0;
            timestamp_valid <= 1'b0;
            last_of_run     <= 1'b1;
            case (info.wclass)
              tdcrd_pkg::WC_HEADER: begin
                if (start_drain) begin
                  state      <= ST_DRAIN;
                  word_valid <= 1'b1;
                  emit_idx   <= '0;
                  drain_ts   <= '0;
                  drain_tv   <= 1'b0;
                  bad_after  <= info.header_bad;
                end else if (info.header_bad) begin
                  out_valid <= 1'b1;
                  kind      <= tdcrd_pkg::KIND_BAD_HDR;
                end
                if (ts_mode == tdcrd_pkg::MODE_EXT) begin
                  ts_high_bits <= '0;
                  ts_high_seen <= 1'b0;
                end
              end
              tdcrd_pkg::WC_HIT: begin
                if (!held) begin
                  out_valid       <= 1'b1;
                  kind            <= tdcrd_pkg::KIND_HIT;
                  channel         <= info.channel;
                  fine_time       <= info.fine;
                  timestamp       <= event_counter;
                  timestamp_valid <= 1'b1;
                end else if (pending_count < CNT_MAX) begin
                  pending_count <= pending_count + CW'(1);
                end else begin
                  out_valid <= 1'b1;
                  kind      <= tdcrd_pkg::KIND_OVERFLOW;
                end
              end
              tdcrd_pkg::WC_EXT: begin
                ts_high_bits <= info.fine;
                ts_high_seen <= 1'b1;
              end
              tdcrd_pkg::WC_BAD_DATA: begin
                out_valid <= 1'b1;
                kind      <= tdcrd_pkg::KIND_BAD_DATA;
              end
              tdcrd_pkg::WC_EOE: begin
                if (ts_mode == tdcrd_pkg::MODE_COUNTER) begin
                  event_counter <= event_counter + tdcrd_pkg::TS_W'(1);
                end else if (start_drain) begin
                  state      <= ST_DRAIN;
                  word_valid <= 1'b1;
                  emit_idx   <= '0;
                  bad_after  <= 1'b0;
                  if (ts_mode == tdcrd_pkg::MODE_TS) begin
                    drain_ts <= {{tdcrd_pkg::TSHI_W{1'b0}}, info.ts_low};
                    drain_tv <= 1'b1;
                  end else begin
                    drain_ts <= ts_high_seen ? {ts_high_bits, info.ts_low} : '0;
                    drain_tv <= ts_high_seen;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        ST_DRAIN: begin
          // RAM data always belongs to emit_idx here; it holds while stalled
          if (out_free) begin
            out_valid       <= 1'b1;
            kind            <= tdcrd_pkg::KIND_HIT;
            module_id       <= module_number;
            channel         <= ram_rdata[tdcrd_pkg::HIT_W-1:tdcrd_pkg::FT_W];
            fine_time       <= ram_rdata[tdcrd_pkg::FT_W-1:0];
            timestamp       <= drain_ts;
            timestamp_valid <= drain_tv;
            last_of_run     <= last_hit && !bad_after;
            if (last_hit) begin
              pending_count <= '0;
              if (bad_after) begin
                state <= ST_BAD_HDR;
              end else begin
                state      <= ST_IDLE;
                word_valid <= 1'b0;
              end
            end else begin
              emit_idx <= emit_idx_next;
            end
          end
        end
        ST_BAD_HDR: begin
          if (out_free) begin
            out_valid       <= 1'b1;
            kind            <= tdcrd_pkg::KIND_BAD_HDR;
            module_id       <= module_number;
            channel         <= '0;
            fine_time       <= '0;
            timestamp       <= '0;
            timestamp_valid <= 1'b0;
            last_of_run     <= 1'b1;
            state           <= ST_IDLE;
            word_valid      <= 1'b0;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    pending_count <= CNT_MAX)
    else $error("hit buffer fill count beyond depth");

  a_drain_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN) |-> (pending_count != '0) && (emit_idx < pending_count))
    else $error("drain running on an empty or overrun buffer");

  a_busy_holds_word: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> word_valid && !in_ready)
    else $error("input taken while a drain is in progress");

  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind != tdcrd_pkg::KIND_HIT) |->
      !timestamp_valid && (timestamp == '0) && (channel == '0) && (fine_time == '0))
    else $error("error beat carries hit payload");

  a_invalid_ts_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !timestamp_valid |-> (timestamp == '0))
    else $error("invalid timestamp not zero");

endmodule

// ----- bench/tdcrd_checker.sv -----
`timescale 1ns / 100ps
// Result checker for the TDC readout word decoder: mirrors the decode and compares beats.
module tdcrd_checker #(
  parameter int unsigned MAX_HITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [tdcrd_pkg::CFGI_W-1:0] cfg_index,
  input  logic [tdcrd_pkg::CFGD_W-1:0] cfg_data,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [tdcrd_pkg::WORD_W-1:0] data_word,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [1:0]                   kind,
  input  logic [7:0]                   module_id,
  input  logic [tdcrd_pkg::CH_W-1:0]   channel,
  input  logic [tdcrd_pkg::FT_W-1:0]   fine_time,
  input  logic [tdcrd_pkg::TS_W-1:0]   timestamp,
  input  logic                         timestamp_valid,
  input  logic                         last_of_run,
  output int                           fail_count,
  output int                           outstanding,
  output int                           beats_seen
);

  typedef struct packed {
    logic [1:0]                 kind;
    logic [7:0]                 mod_id;
    logic [tdcrd_pkg::CH_W-1:0] ch;
    logic [tdcrd_pkg::FT_W-1:0] ft;
    logic [tdcrd_pkg::TS_W-1:0] ts;
    logic                       ts_ok;
    logic                       last;
  } decoded_t;

  decoded_t decoded_q[$];

  logic [1:0]                   mode;
  logic [7:0]                   module_num;
  logic [tdcrd_pkg::TS_W-1:0]   evt_count;
  logic [tdcrd_pkg::HIT_W-1:0]  held_hits [MAX_HITS];
  int unsigned                  held_cnt;
  logic [tdcrd_pkg::TSHI_W-1:0] ts_hi;
  logic                         ts_hi_seen;
  int                           emitted;
  int                           errs = 0;
  int                           checked = 0;

  task automatic emit(input logic [1:0] k, input logic [tdcrd_pkg::CH_W-1:0] ch,
                      input logic [tdcrd_pkg::FT_W-1:0] ft,
                      input logic [tdcrd_pkg::TS_W-1:0] ts, input logic ok);
    decoded_t r;
    r.kind   = k;
    r.mod_id = module_num;
    r.ch     = ch;
    r.ft     = ft;
    r.ts     = ok ? ts : '0;
    r.ts_ok  = ok;
    r.last   = 1'b0;
    decoded_q = {decoded_q, r};
    emitted++;
  endtask

  task automatic flush_held(input logic [tdcrd_pkg::TS_W-1:0] ts, input logic ok);
    for (int unsigned i = 0; i < held_cnt; i++)
      emit(tdcrd_pkg::KIND_HIT, held_hits[i][tdcrd_pkg::HIT_W-1:tdcrd_pkg::FT_W],
           held_hits[i][tdcrd_pkg::FT_W-1:0], ts, ok);
    held_cnt = 0;
  endtask

  task automatic decode_word(input logic [tdcrd_pkg::WORD_W-1:0] w);
    logic     held;
    decoded_t r;
    held    = (mode == tdcrd_pkg::MODE_TS) || (mode == tdcrd_pkg::MODE_EXT);
    emitted = 0;
    if (mode != tdcrd_pkg::MODE_OFF) begin
      case (w[31:30])
        tdcrd_pkg::TOP_HEADER: begin
          // a fresh header sends out whatever the last event left behind, with no timestamp
          if (held) begin
            flush_held('0, 1'b0);
            if (mode == tdcrd_pkg::MODE_EXT) begin
              ts_hi      = '0;
              ts_hi_seen = 1'b0;
            end
          end
          if (w[31:24] != tdcrd_pkg::HDR_ID)
            emit(tdcrd_pkg::KIND_BAD_HDR, '0, '0, '0, 1'b0);
        end
        tdcrd_pkg::TOP_DATA: begin
          if (w[31:22] == tdcrd_pkg::HIT_ID) begin
            if (!held) begin
              emit(tdcrd_pkg::KIND_HIT, w[20:16], w[15:0], evt_count, 1'b1);
            end else if (held_cnt < MAX_HITS) begin
              held_hits[held_cnt] = w[tdcrd_pkg::HIT_W-1:0];
              held_cnt++;
            end else begin
              emit(tdcrd_pkg::KIND_OVERFLOW, '0, '0, '0, 1'b0);
            end
          end else if (mode == tdcrd_pkg::MODE_EXT && w[31:16] == tdcrd_pkg::EXT_ID) begin
            ts_hi      = w[tdcrd_pkg::TSHI_W-1:0];
            ts_hi_seen = 1'b1;
          end else if (w != '0) begin
            emit(tdcrd_pkg::KIND_BAD_DATA, '0, '0, '0, 1'b0);
          end
        end
        tdcrd_pkg::TOP_EOE: begin
          if (mode == tdcrd_pkg::MODE_COUNTER)
            evt_count = evt_count + tdcrd_pkg::TS_W'(1);
          else if (mode == tdcrd_pkg::MODE_TS)
            flush_held(tdcrd_pkg::TS_W'(w[tdcrd_pkg::TSLO_W-1:0]), 1'b1);
          else
            flush_held({ts_hi, w[tdcrd_pkg::TSLO_W-1:0]}, ts_hi_seen);
        end
        default: ;
      endcase
    end
    if (emitted > 0) begin
      r = decoded_q.pop_back();
      r.last = 1'b1;
      decoded_q = {decoded_q, r};
    end
  endtask

  task automatic check_beat();
    decoded_t want;
    decoded_t got;
    got = {kind, module_id, channel, fine_time, timestamp, timestamp_valid, last_of_run};
    checked++;
    if (decoded_q.size() == 0) begin
      errs++;
      if (errs <= 10)
        $display("[%0t] unexpected result beat: kind %0d ch %0d fine %h ts %h",
                 $realtime, got.kind, got.ch, got.ft, got.ts);
    end else begin
      want = decoded_q.pop_front();
      if (got !== want) begin
        errs++;
        if (errs <= 10) begin
          $write("[%0t] beat %0d exp/act: kind %0d/%0d mod %0d/%0d ch %0d/%0d ",
                 $realtime, checked, want.kind, got.kind, want.mod_id, got.mod_id,
                 want.ch, got.ch);
          $display("fine %h/%h ts %h/%h tsv %b/%b last %b/%b",
                   want.ft, got.ft, want.ts, got.ts,
                   want.ts_ok, got.ts_ok, want.last, got.last);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      mode       = tdcrd_pkg::MODE_COUNTER;
      module_num = '0;
      evt_count  = '0;
      held_cnt   = 0;
      ts_hi      = '0;
      ts_hi_seen = 1'b0;
      decoded_q.delete();
    end else begin
      // output beats at this edge belong to words taken earlier
      if (out_valid && out_ready)
        check_beat();
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tdcrd_pkg::CFG_TS_MODE: mode = cfg_data[1:0];
          tdcrd_pkg::CFG_MODULE:  module_num = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        decode_word(data_word);
    end
    outstanding <= decoded_q.size();
    fail_count  <= errs;
    beats_seen  <= checked;
  end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// Testbench top for the TDC readout word decoder: stimulus, handshake idling and verdict.
module tb_top;

  localparam int unsigned MAX_HITS   = 32;
  localparam int unsigned LIMIT      = 400000;
  localparam int unsigned SETTLE     = 40;
  localparam int unsigned RAND_ITEMS = 170;

  logic                         clk       = 1'b0;
  logic                         rst       = 1'b1;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [tdcrd_pkg::CFGI_W-1:0] cfg_index = '0;
  logic [tdcrd_pkg::CFGD_W-1:0] cfg_data  = '0;
  logic                         in_valid  = 1'b0;
  logic                         in_ready;
  logic [tdcrd_pkg::WORD_W-1:0] data_word = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [1:0]                   kind;
  logic [7:0]                   module_id;
  logic [tdcrd_pkg::CH_W-1:0]   channel;
  logic [tdcrd_pkg::FT_W-1:0]   fine_time;
  logic [tdcrd_pkg::TS_W-1:0]   timestamp;
  logic                         timestamp_valid;
  logic                         last_of_run;

  int          fail_count;
  int          outstanding;
  int          beats_seen;
  int unsigned cyc = 0;
  logic        calm = 1'b0;

  logic [1:0]  cur_mode = tdcrd_pkg::MODE_COUNTER;
  int unsigned words_sent  = 0;
  int unsigned live_words  = 0;
  int unsigned progress    = 0;
  int unsigned n_settings  = 0;

  tdc_readout_word_decoder_unit #(.MAX_HITS(MAX_HITS)) uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .data_word(data_word),
    .out_valid(out_valid), .out_ready(out_ready), .kind(kind), .module_id(module_id),
    .channel(channel), .fine_time(fine_time), .timestamp(timestamp),
    .timestamp_valid(timestamp_valid), .last_of_run(last_of_run)
  );

  tdcrd_checker #(.MAX_HITS(MAX_HITS)) u_checker (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .data_word(data_word),
    .out_valid(out_valid), .out_ready(out_ready), .kind(kind), .module_id(module_id),
    .channel(channel), .fine_time(fine_time), .timestamp(timestamp),
    .timestamp_valid(timestamp_valid), .last_of_run(last_of_run),
    .fail_count(fail_count), .outstanding(outstanding), .beats_seen(beats_seen)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) cyc <= cyc + 1;

  always @(posedge clk) out_ready <= calm || ($urandom_range(99) >= 15);

  initial begin
    wait (cyc >= LIMIT);
    $display("timeout after %0d cycles, %0d results still due", cyc, outstanding);
    $display("*** FAILED ***");
    $finish;
  end

  // both registers in one go; valid stays up between the two beats
  task automatic set_config(input logic [1:0] m, input logic [7:0] mod);
    cfg_valid <= 1'b1;
    cfg_index <= tdcrd_pkg::CFG_TS_MODE;
    cfg_data  <= tdcrd_pkg::CFGD_W'(m);
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= tdcrd_pkg::CFG_MODULE;
    cfg_data  <= mod;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_mode = m;
    n_settings++;
  endtask

  // hold the sender until every due result is out, then let the block go quiet
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic send_word(input logic [tdcrd_pkg::WORD_W-1:0] w);
    bit live;
    if (!calm && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_word <= w;
    do @(posedge clk); while (!in_ready);
    live = (cur_mode != tdcrd_pkg::MODE_OFF) && (w != '0) && (w[31:30] != tdcrd_pkg::TOP_FILL);
    words_sent++;
    if (live) live_words++;
    if (live || cur_mode == tdcrd_pkg::MODE_OFF) progress++;
  endtask

  task automatic send_noise();
    logic [tdcrd_pkg::WORD_W-1:0] w;
    case ($urandom_range(5))
      0: w = $urandom;
      1: w = '0;
      2: w = {tdcrd_pkg::TOP_FILL, 30'($urandom)};
      3: w = {tdcrd_pkg::TOP_HEADER, 6'($urandom_range(63, 1)), 24'($urandom)};
      4: begin
        w = {tdcrd_pkg::TOP_DATA, 30'($urandom)};
        if (w[31:22] == tdcrd_pkg::HIT_ID) w[26] = 1'b0;
      end
      default: w = {tdcrd_pkg::EXT_ID, 16'($urandom)};
    endcase
    send_word(w);
  endtask

  // header, optional extended word among the hits, hits, mostly an end-of-event
  task automatic send_event(input int unsigned nhits);
    int unsigned ext_at;
    ext_at = nhits + 1;
    if ($urandom_range(99) < (cur_mode == tdcrd_pkg::MODE_EXT ? 75 : 10))
      ext_at = $urandom_range(nhits, 0);
    if ($urandom_range(99) < 90)
      send_word({tdcrd_pkg::HDR_ID, 24'($urandom)});
    else
      send_word({tdcrd_pkg::TOP_HEADER, 6'($urandom_range(63, 1)), 24'($urandom)});
    for (int unsigned i = 0; i <= nhits; i++) begin
      if (i == ext_at) send_word({tdcrd_pkg::EXT_ID, 16'($urandom)});
      if (i < nhits) send_word({tdcrd_pkg::HIT_ID, 22'($urandom)});
    end
    if ($urandom_range(99) < 90)
      send_word({tdcrd_pkg::TOP_EOE, 30'($urandom)});
  endtask

  task automatic random_phase(input logic [1:0] m, input logic [7:0] mod,
                              input bit force_long, input int unsigned rand_base);
    int unsigned start;
    int unsigned quota;
    bit          paused;
    settle();
    set_config(m, mod);
    start  = progress;
    quota  = (m == tdcrd_pkg::MODE_OFF) ? 12 : 30;
    paused = 1'b0;
    if (force_long) send_event(33);
    while (progress - start < quota && words_sent < RAND_ITEMS) begin
      calm <= (live_words - rand_base >= 50) && (live_words - rand_base < 100);
      if (!paused && progress - start >= quota / 2) begin
        settle();
        paused = 1'b1;
      end
      if ($urandom_range(99) < 80)
        send_event($urandom_range(99) < 8 ? $urandom_range(36, 30) : $urandom_range(6, 0));
      else
        repeat ($urandom_range(3, 1)) send_noise();
    end
  endtask

  logic [1:0] phase_modes [7] = '{tdcrd_pkg::MODE_TS, tdcrd_pkg::MODE_EXT,
                                  tdcrd_pkg::MODE_COUNTER, tdcrd_pkg::MODE_OFF,
                                  tdcrd_pkg::MODE_EXT, tdcrd_pkg::MODE_COUNTER,
                                  tdcrd_pkg::MODE_TS};

  initial begin
    int unsigned rand_base;
    int unsigned k;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // event counter mode: hits go straight out
    set_config(tdcrd_pkg::MODE_COUNTER, 8'hFF);
    send_word(32'h0400_0000);
    send_word(32'h043F_FFFF);
    send_word(32'hFFFF_FFFF);
    send_word(32'h0415_A5A5);
    send_word(32'h40FF_FFFF);
    send_word(32'h7FFF_FFFF);
    send_word(32'h0000_0000);
    send_word(32'h3FFF_FFFF);
    send_word(32'hBFFF_FFFF);
    settle();

    // 30-bit timestamp mode; last hit is left pending across the mode changes
    set_config(tdcrd_pkg::MODE_TS, 8'h00);
    send_word(32'h4000_0000);
    send_word(32'h0401_1111);
    send_word(32'h041E_2222);
    send_word(32'hC000_0000);
    send_word(32'h0403_3333);
    send_word(32'h4012_3456);
    send_word(32'h0480_1234);
    send_word(32'hFFFF_FFFF);
    send_word(32'h0404_4444);
    settle();

    set_config(tdcrd_pkg::MODE_OFF, 8'h5A);
    send_word(32'h0405_5555);
    send_word(32'hC000_0001);
    settle();

    // extended mode: leftover hit drains here, then missing and freshly set high bits
    set_config(tdcrd_pkg::MODE_EXT, 8'hA5);
    send_word(32'h0480_FFFF);
    send_word(32'hFFFF_FFFF);
    send_word(32'h4000_0001);
    send_word(32'h0406_6666);
    send_word(32'hC000_0002);
    send_word(32'h0480_0000);
    send_word(32'h0407_7777);
    send_word(32'hC000_0003);

    rand_base = live_words;
    k = 0;
    while (words_sent < RAND_ITEMS) begin
      random_phase(phase_modes[k % 7],
                   (k == 0) ? 8'h00 : (k == 1) ? 8'hFF : 8'($urandom),
                   k == 1, rand_base);
      k++;
    end
    calm <= 1'b0;
    settle();

    $display("Sent %0d words (%0d decoded) under %0d register settings; %0d result beats checked.",
             words_sent, live_words, n_settings, beats_seen);
    if (fail_count == 0 && outstanding == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/tdcrd_pkg.sv
rtl/core/tdcrd_ram.sv
rtl/core/tdcrd_classify.sv
rtl/core/tdc_readout_word_decoder_unit.sv
bench/tdcrd_checker.sv
bench/tb_top.sv
